// File: hdl/mnt_pkg.sv
// ----------------------------------------------------------------------------
// mnt_pkg
// Shared types, constants and helpers for the MIDI note transposer.
// ----------------------------------------------------------------------------
package mnt_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 7;
  localparam int unsigned CountW = 2;
  localparam int unsigned SumW   = 9;

  localparam logic [3:0] KindNoteOff = 4'h8;
  localparam logic [3:0] KindNoteOn  = 4'h9;
  localparam logic [3:0] KindPolyAt  = 4'hA;
  localparam logic [3:0] KindCtrl    = 4'hB;
  localparam logic [3:0] KindProg    = 4'hC;
  localparam logic [3:0] KindChanAt  = 4'hD;
  localparam logic [3:0] KindBend    = 4'hE;

  localparam logic signed [ByteW-1:0] TransposeReset = 8'sd6;

  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] status;
    logic [DataW-1:0] note;
    logic [DataW-1:0] velocity;
  } result_t;

  // number of data bytes a status byte calls for
  function automatic count_t expected_data(input logic [ByteW-1:0] status);
    count_t n;
    case (status[7:4]) inside
      KindNoteOff, KindNoteOn, KindPolyAt, KindCtrl, KindBend: n = count_t'(2);
      KindProg, KindChanAt: n = count_t'(1);
      default: n = count_t'(0);
    endcase
    return n;
  endfunction

endpackage

// File: hdl/mnt_if.sv
// ----------------------------------------------------------------------------
// mnt interfaces
// Valid/ready channels for raw bytes, transposed notes and configuration.
// ----------------------------------------------------------------------------
interface mnt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mnt_note_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_status;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  modport source (output valid, output out_status, output out_note,
                  output out_velocity, input ready);
  modport sink   (input valid, input out_status, input out_note,
                  input out_velocity, output ready);
endinterface

interface mnt_cfg_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] transpose_amount;
  modport source (output valid, output transpose_amount, input ready);
  modport sink   (input valid, input transpose_amount, output ready);
endinterface

// File: hdl/mnt_parser.sv
// ----------------------------------------------------------------------------
// mnt_parser
// Running-status parser state and note transpose for one registered byte.
// ----------------------------------------------------------------------------
module mnt_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic [mnt_pkg::ByteW-1:0]        byte_i,
  input  logic signed [mnt_pkg::ByteW-1:0] transpose_i,
  output mnt_pkg::result_t                 result_o
);
  import mnt_pkg::*;

  logic [ByteW-1:0] status_q, status_d;
  count_t           remain_q, remain_d;
  logic [DataW-1:0] first_q, first_d;
  count_t           remain_eff;
  logic signed [SumW-1:0] sum;
  logic             is_note;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      remain_q <= '0;
      first_q  <= '0;
    end else if (fire_i) begin
      status_q <= status_d;
      remain_q <= remain_d;
      first_q  <= first_d;
    end
  end

  // running status reloads the count once a message is done
  assign remain_eff = (remain_q == count_t'(0)) ? expected_data(status_q) : remain_q;
  assign is_note    = (status_q[7:4] == KindNoteOff) || (status_q[7:4] == KindNoteOn);
  assign sum = $signed({2'b00, first_q}) + SumW'(transpose_i);

  always_comb begin
    status_d = status_q;
    remain_d = remain_q;
    first_d  = first_q;
    result_o = '0;
    result_o.status   = status_q;
    result_o.note     = sum[DataW-1:0];
    result_o.velocity = byte_i[DataW-1:0];
    if (byte_i[7]) begin
      status_d = byte_i;
      remain_d = expected_data(byte_i);
    end else if (remain_eff == count_t'(2)) begin
      first_d  = byte_i[DataW-1:0];
      remain_d = count_t'(1);
    end else begin
      remain_d = count_t'(0);
      // note from 1 through 127
      result_o.valid = (remain_eff == count_t'(1)) && is_note &&
                       (sum[SumW-1:DataW] == '0) && (sum[DataW-1:0] != '0);
    end
  end

endmodule

// File: hdl/mnt_out_reg.sv
// ----------------------------------------------------------------------------
// mnt_out_reg
// Result register driving the note channel.
// ----------------------------------------------------------------------------
module mnt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mnt_pkg::result_t result_i,
  output logic             free_o,
  mnt_note_if.source       note_o
);
  import mnt_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] status_q;
  logic [DataW-1:0] note_q, vel_q;

  assign free_o = !valid_q || note_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (note_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= result_i.status;
      note_q   <= result_i.note;
      vel_q    <= result_i.velocity;
    end
  end

  assign note_o.valid        = valid_q;
  assign note_o.out_status   = status_q;
  assign note_o.out_note     = note_q;
  assign note_o.out_velocity = vel_q;

endmodule

// File: hdl/midi_note_transposer_top.sv
// ----------------------------------------------------------------------------
// midi_note_transposer_top
// A byte that completes a note message passes through the input register, then
// the combinational parser, then the result register.
// Throughput: one byte per cycle while the note channel keeps up.
// Reset: parser state cleared, both registers empty, transpose set to +6.
// ----------------------------------------------------------------------------
module midi_note_transposer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mnt_byte_if.sink   byte_i,
  mnt_cfg_if.sink    cfg_i,
  mnt_note_if.source note_o
);
  import mnt_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic signed [ByteW-1:0] transpose_q;
  logic             fire;
  logic             out_free;
  result_t          result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= TransposeReset;
    end else if (cfg_i.valid) begin
      transpose_q <= cfg_i.transpose_amount;
    end
  end

  // a byte leaves the input register unless its result finds the output full
  assign fire         = in_valid_q && (!result.valid || out_free);
  assign byte_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.midi_byte;
    end
  end

  mnt_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .transpose_i (transpose_q),
    .result_o    (result)
  );

  mnt_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && result.valid),
    .result_i (result),
    .free_o   (out_free),
    .note_o   (note_o)
  );

`ifndef ASSERT_OFF
  a_note_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_o.valid |-> (note_o.out_note != 7'd0))
    else $error("transposed note out of range");

  a_note_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_o.valid |-> (note_o.out_status[7:5] == 3'b100))
    else $error("result status is not a note message");

  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled byte lost from input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && result.valid) |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

// File: tb/midi_note_transposer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_transposer_top_test
// Streams raw MIDI bytes into the transposer over valid/ready channels and
// checks every emitted note message against a cycle-free predictor. A short
// table covers the edge cases, then random phases sweep the transpose setting
// with running status, real-time bytes, broken messages and random stalls.
// ----------------------------------------------------------------------------
module midi_note_transposer_top_test;
  import mnt_pkg::*;

  localparam int          HalfPeriod  = 5;
  localparam int          ResetCycles = 6;
  localparam int          DrainCycles = 4;
  localparam int          HoldCycles  = 300;
  localparam int          CycleLimit  = 400000;
  localparam int          Phases      = 10;
  localparam int          PhaseBytes  = 155;
  localparam int          HoldPhase   = 2;
  localparam logic [3:0]  KindSystem  = 4'hF;
  localparam logic [7:0]  RealTime    = 8'hF8;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] velocity;
  } note_msg_t;

  // one row of the directed plan: a byte, or a transpose write
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] value;
    logic       typed;
    logic       emits;
    note_msg_t  msg;
  } plan_row_t;

  localparam int PlanRows = 34;

  plan_row_t plan [PlanRows] = '{
    '{1'b0, 8'h40, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // data before any status
    '{1'b0, 8'h90, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h3C, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h7F, 1'b1, 1'b1, '{8'h90, 7'd66,  7'd127}},
    '{1'b0, 8'h00, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // running status, note 0
    '{1'b0, 8'h00, 1'b1, 1'b1, '{8'h90, 7'd6,   7'd0}},
    '{1'b0, 8'h7F, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h40, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // 133 swallowed
    '{1'b0, 8'h8F, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h79, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h2A, 1'b1, 1'b1, '{8'h8F, 7'd127, 7'h2A}},  // lands on 127, kept
    '{1'b0, 8'h78, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h55, 1'b1, 1'b1, '{8'h8F, 7'd126, 7'h55}},
    '{1'b0, 8'h9A, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h10, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'hF8, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // real-time cuts the message
    '{1'b0, 8'h20, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'hC3, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h05, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'hE0, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h00, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h7F, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b1, 8'h80, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},   // transpose -128
    '{1'b0, 8'h95, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h7F, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h01, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // lands on -1
    '{1'b1, 8'h7F, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},   // transpose +127
    '{1'b0, 8'h00, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h33, 1'b1, 1'b1, '{8'h95, 7'd127, 7'h33}},
    '{1'b1, 8'hFF, 1'b0, 1'b0, '{8'h00, 7'd0,   7'd0}},   // transpose -1
    '{1'b0, 8'h01, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h02, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},   // lands on 0
    '{1'b0, 8'h02, 1'b1, 1'b0, '{8'h00, 7'd0,   7'd0}},
    '{1'b0, 8'h02, 1'b1, 1'b1, '{8'h95, 7'd1,   7'd2}}
  };

  logic clk;
  logic rst_n;

  mnt_byte_if byte_ch ();
  mnt_cfg_if  cfg_ch ();
  mnt_note_if note_ch ();

  midi_note_transposer_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_ch),
    .cfg_i  (cfg_ch),
    .note_o (note_ch)
  );

  // parser copy
  logic [7:0]        run_status;
  logic [2:0]        data_left;
  logic [6:0]        first_note;
  logic              stream_seen;
  logic signed [7:0] shift_amt;

  note_msg_t pending_notes[$];

  int  error_count;
  int  bytes_sent;
  int  notes_checked;
  int  cfg_writes;
  int  cycle_count;
  bit  sender_idle;
  bit  receiver_idle;
  bit  hold_request;

  initial clk = 1'b0;
  always #(HalfPeriod) clk = ~clk;

  function automatic logic [2:0] msg_length(input logic [7:0] status);
    case (status[7:4])
      KindNoteOff, KindNoteOn, KindPolyAt, KindCtrl, KindBend: return 3'd2;
      KindProg, KindChanAt: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  // advance the parser by one byte, true when a note message comes out
  function automatic bit transpose_byte(input logic [7:0] b, output note_msg_t msg);
    logic signed [9:0] sum;
    msg = '0;
    if (b[7]) begin
      run_status  = b;
      data_left   = msg_length(b);
      stream_seen = 1'b1;
      return 1'b0;
    end
    if (!stream_seen || data_left == 3'd0) begin
      data_left = msg_length(run_status);
    end
    if (data_left == 3'd2) begin
      first_note = b[6:0];
      data_left  = 3'd1;
      return 1'b0;
    end
    if (data_left != 3'd1) begin
      data_left = 3'd0;
      return 1'b0;
    end
    data_left = 3'd0;
    if (run_status[7:4] != KindNoteOff && run_status[7:4] != KindNoteOn) begin
      return 1'b0;
    end
    sum = $signed({3'b000, first_note}) + shift_amt;
    if (sum <= 0 || sum >= 128) begin
      return 1'b0;
    end
    msg = '{run_status, sum[6:0], b[6:0]};
    return 1'b1;
  endfunction

  // offer one byte; table rows may carry their own expectation
  task automatic offer_byte(input logic [7:0] b, input bit typed, input bit emits,
                            input note_msg_t typed_msg);
    int        gap;
    note_msg_t msg;
    bit        hit;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.midi_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    hit = transpose_byte(b, msg);
    if (typed) begin
      if (emits) pending_notes.push_back(typed_msg);
    end else if (hit) begin
      pending_notes.push_back(msg);
    end
    bytes_sent++;
  endtask

  task automatic stop_bytes();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_transpose(input logic [7:0] value);
    stop_bytes();
    wait_drained();
    @(negedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.transpose_amount <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    shift_amt = value;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic offer_data(input logic [7:0] b);
    offer_byte(b, 1'b0, 1'b0, '0);
  endtask

  // one random stretch: mostly whole messages, some noise and broken ones
  task automatic send_burst();
    int         r;
    int         k;
    logic [3:0] kind;
    logic [7:0] st;
    logic [2:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      if (r < 20) begin
        st = run_status;       // running status, no status byte
      end else begin
        k = $urandom_range(0, 9);
        if (k < 4) kind = KindNoteOn;
        else if (k < 7) kind = KindNoteOff;
        else begin
          case ($urandom_range(0, 4))
            0: kind = KindPolyAt;
            1: kind = KindCtrl;
            2: kind = KindProg;
            3: kind = KindChanAt;
            default: kind = KindBend;
          endcase
        end
        st = {kind, 4'($urandom_range(0, 15))};
        offer_data(st);
      end
      cnt = msg_length(st);
      for (int i = 0; i < int'(cnt); i++) begin
        if ($urandom_range(0, 19) == 0) offer_data(RealTime | 8'($urandom_range(0, 7)));
        offer_data(8'($urandom_range(0, 127)));
      end
    end else if (r < 88) begin
      offer_data(8'($urandom_range(0, 255)));
    end else if (r < 94) begin
      offer_data({KindSystem, 4'($urandom_range(0, 15))});
      k = $urandom_range(0, 2);
      repeat (k) offer_data(8'($urandom_range(0, 127)));
    end else begin
      // message cut short by whatever comes next
      offer_data({KindNoteOn, 4'($urandom_range(0, 15))});
      offer_data(8'($urandom_range(0, 127)));
    end
  endtask

  // note receiver, with one long hold-off on request
  initial begin
    int gap;
    note_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        note_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        gap = receiver_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
          note_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      note_ch.ready <= 1'b1;
      do @(posedge clk); while (!(note_ch.valid && note_ch.ready));
    end
  end

  always @(posedge clk) begin
    note_msg_t want;
    if (rst_n && note_ch.valid && note_ch.ready) begin
      if (pending_notes.size() == 0) begin
        $display("%0t: unexpected note: status %h note %0d velocity %0d", $time,
                 note_ch.out_status, note_ch.out_note, note_ch.out_velocity);
        error_count++;
      end else begin
        want = pending_notes.pop_front();
        if (note_ch.out_status !== want.status || note_ch.out_note !== want.note ||
            note_ch.out_velocity !== want.velocity) begin
          $display("%0t: note mismatch: expected status %h note %0d velocity %0d, got %h %0d %0d",
                   $time, want.status, want.note, want.velocity,
                   note_ch.out_status, note_ch.out_note, note_ch.out_velocity);
          error_count++;
        end
        notes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d notes outstanding", $time, pending_notes.size());
      $display("midi_note_transposer_top_test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] value;
    int         phase_end;
    error_count   = 0;
    bytes_sent    = 0;
    notes_checked = 0;
    cfg_writes    = 0;
    cycle_count   = 0;
    hold_request  = 1'b0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    run_status    = '0;
    data_left     = '0;
    first_note    = '0;
    stream_seen   = 1'b0;
    shift_amt     = TransposeReset;

    rst_n                   = 1'b0;
    byte_ch.valid           = 1'b0;
    byte_ch.midi_byte       = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.transpose_amount = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PlanRows; i++) begin
      if (plan[i].is_cfg) write_transpose(plan[i].value);
      else offer_byte(plan[i].value, plan[i].typed, plan[i].emits, plan[i].msg);
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        1: value = 8'h7F;
        3: value = 8'h80;
        4: value = 8'h00;
        5: value = 8'h81;
        6: value = 8'hFF;
        7: value = 8'h01;
        8, 9: value = 8'($urandom_range(0, 255));
        default: value = 8'($urandom_range(0, 24) - 12);
      endcase
      write_transpose(value);
      if (p == 1) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end else if (p == HoldPhase) begin
        // keep the input busy while the receiver holds off
        sender_idle   = 1'b0;
        receiver_idle = 1'b1;
        hold_request  = 1'b1;
      end else begin
        sender_idle   = $urandom_range(0, 3) != 0;
        receiver_idle = $urandom_range(0, 3) != 0;
      end
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_burst();
    end

    stop_bytes();
    wait_drained();

    $display("covered %0d bytes and %0d checked notes over %0d transpose writes",
             bytes_sent, notes_checked, cfg_writes);
    $display("settings included -128, -127, -1, 0, +1, +127 and random offsets");
    if (error_count == 0 && pending_notes.size() == 0) begin
      $display("midi_note_transposer_top_test passed");
    end else begin
      $display("midi_note_transposer_top_test failed");
    end
    $finish;
  end

endmodule
